>>> src/phase_delay_trimmed_mean_assert.svh
// Assertion macros shared by the phase delay trimmed mean RTL
`ifndef PHASE_DELAY_TRIMMED_MEAN_ASSERT_SVH
`define PHASE_DELAY_TRIMMED_MEAN_ASSERT_SVH
`ifndef SYNTHESIS
`define PDTM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PDTM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PDTM_ASSERT(lbl, clk, rst_n, prop, msg)
`define PDTM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> src/pdtm_pkg.sv
// Shared widths, constants and controller/datapath interface types
package pdtm_pkg;

    localparam int PHASE_W  = 16;
    localparam int CALIB_W  = 17;
    localparam int EST_W    = 15;
    localparam int SAMPLE_W = 15;
    localparam int DIFF_W   = 19;   // a - b - bias - calib never leaves +-2^18
    localparam int DMAG_W   = 15;   // |d| of an in-range difference
    localparam int SNUM_W   = DMAG_W + 2;   // 5|d| + 4 of an in-range difference

    localparam int BATCH_LEN_DEF = 50;

    localparam int PHASE_BIAS = 5100;
    localparam int HALF_TURN  = 18000;
    localparam int OUT_LIMIT  = 10000;
    // sample = round(5|d|/9) = (5|d| + 4) / 9, sign restored afterwards
    localparam int SAMPLE_RND = 4;
    localparam int SAMPLE_DEN = 9;

    typedef struct packed {
        logic accept;      // latch sign, start sample scaling
        logic key_load;    // latch rounded sample, start insertion
        logic ins_step;    // shift one entry up
        logic ins_place;   // write key at its slot
        logic rd_shift;    // read address follows insertion pointer
        logic rd_sum;      // read address follows sum sweep
        logic sum_init;
        logic sum_run;
        logic est_start;   // start estimate scaling
        logic emit;        // register estimate, pulse strobe
    } t_dp_cmd;

    typedef struct packed {
        logic in_range;
        logic div_done;
        logic j_zero;
        logic gt;
        logic last_sample;
        logic sum_done;
    } t_dp_status;

endpackage

>>> src/phase_delay_trimmed_mean.sv
// Top level of the phase delay trimmed mean estimator
// A word (phase_a, phase_b) is taken when start is high while busy is low.
// A pair whose difference is not strictly inside +-180 degrees is dropped
// as it is taken and busy stays low. Any other pair holds busy high after it
// is taken, for the reciprocal scaling to hundredths and for the insertion
// sort walking down the sample RAM, one entry per cycle, over k entries where
// k <= fill count. The pair that closes a batch adds a sweep over the
// middle entries and the estimate scaling. The estimate appears on
// o_delay_estimate with o_valid high for exactly one cycle, the first cycle
// with busy low again; there is no backpressure, so capture it then.
module phase_delay_trimmed_mean import pdtm_pkg::*; #(
    parameter int BATCH_LEN = BATCH_LEN_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cfg_we,
    input  logic signed [CALIB_W-1:0]  i_cfg_wdata,
    input  logic signed [PHASE_W-1:0]  i_phase_a,
    input  logic signed [PHASE_W-1:0]  i_phase_b,
    output logic                       o_valid,
    output logic signed [EST_W-1:0]    o_delay_estimate
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    pdtm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    pdtm_dp #(
        .BATCH_LEN (BATCH_LEN)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_phase_a        (i_phase_a),
        .i_phase_b        (i_phase_b),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_valid          (o_valid),
        .o_delay_estimate (o_delay_estimate)
    );

endmodule

>>> src/pdtm_ram.sv
// Generic single write, single read RAM with registered read data
module pdtm_ram import pdtm_pkg::*; #(
    parameter int WIDTH = SAMPLE_W,
    parameter int DEPTH = BATCH_LEN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/pdtm_div.sv
// Unsigned divide by a constant: reciprocal multiply, numerator and product registered in turn
module pdtm_div import pdtm_pkg::*; #(
    parameter int NUM_W = SNUM_W,
    parameter int DEN   = SAMPLE_DEN
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    // floor(n * RECIP / 2^SHIFT) == floor(n / DEN) for every n < 2^NUM_W,
    // since RECIP * DEN - 2^SHIFT < DEN <= 2^(SHIFT - NUM_W)
    localparam int SHIFT  = NUM_W + $clog2(DEN);
    localparam int REC_W  = NUM_W + 1;
    localparam int PROD_W = NUM_W + REC_W;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN);
    localparam logic [REC_W-1:0] RECIP = REC_W'(RECIP_FULL);

    logic [NUM_W-1:0]  r_num;
    logic [PROD_W-1:0] r_prod;
    logic              r_num_v;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_v <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_num_v <= i_start;
            r_done  <= r_num_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
        end
        if (r_num_v) begin
            r_prod <= PROD_W'(r_num) * PROD_W'(RECIP);
        end
    end

    assign o_done = r_done;
    assign o_quot = NUM_W'(r_prod[PROD_W-1:SHIFT]);

endmodule

>>> src/pdtm_dp.sv
// Datapath: difference, constant scaling, sorted sample store, trimmed sum
`include "phase_delay_trimmed_mean_assert.svh"
module pdtm_dp import pdtm_pkg::*; #(
    parameter int BATCH_LEN = BATCH_LEN_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic signed [CALIB_W-1:0]  i_cfg_wdata,
    input  logic signed [PHASE_W-1:0]  i_phase_a,
    input  logic signed [PHASE_W-1:0]  i_phase_b,
    input  t_dp_cmd                    i_cmd,
    output t_dp_status                 o_status,
    output logic                       o_valid,
    output logic signed [EST_W-1:0]    o_delay_estimate
);

    localparam int AW      = $clog2(BATCH_LEN);
    localparam int TRIM    = BATCH_LEN / 4;
    localparam int KEND    = BATCH_LEN - TRIM;
    localparam int SUM_W   = SAMPLE_W + $clog2(BATCH_LEN);
    localparam int ENUM_W  = SUM_W + 4;
    // estimate = round(11|S|/6N) = (11|S| + 3N) / 6N
    localparam int EST_RND = 3 * BATCH_LEN;
    localparam int EST_DEN = 6 * BATCH_LEN;

    localparam logic signed [DIFF_W-1:0] LIM_HI  = DIFF_W'(HALF_TURN);
    localparam logic signed [DIFF_W-1:0] LIM_LO  = -LIM_HI;
    localparam logic signed [EST_W-1:0]  EST_MAX = EST_W'(OUT_LIMIT);

    logic signed [CALIB_W-1:0]  r_calib;
    logic signed [SAMPLE_W-1:0] r_key;
    logic                       r_neg;
    logic [AW-1:0]              r_fill;
    logic [AW-1:0]              r_j;
    logic [AW-1:0]              r_k;
    logic                       r_acc_v;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [EST_W-1:0]    r_est;
    logic                       r_out_valid;

    logic signed [DIFF_W-1:0]   w_diff;
    logic signed [DIFF_W-1:0]   w_dabs;
    logic [DMAG_W+1:0]          w_mag5;
    logic [SNUM_W-1:0]          w_samp_num;
    logic [SUM_W-1:0]           w_smag;
    logic [ENUM_W-1:0]          w_mag11;
    logic [ENUM_W-1:0]          w_est_num;
    logic                       w_sdiv_done;
    logic                       w_ediv_done;
    logic [SNUM_W-1:0]          w_squot;
    logic [ENUM_W-1:0]          w_equot;
    logic [SAMPLE_W-1:0]        w_q_samp;
    logic [EST_W-2:0]           w_qsat;
    logic signed [EST_W-1:0]    w_est;
    logic [AW-1:0]              w_raddr;
    logic [SAMPLE_W-1:0]        w_rdata;
    logic                       w_we;
    logic [SAMPLE_W-1:0]        w_wdata;

    // phase difference and its rounded scaling to hundredths
    assign w_diff = DIFF_W'(i_phase_a) - DIFF_W'(i_phase_b)
                  - DIFF_W'(PHASE_BIAS) - DIFF_W'(r_calib);
    assign w_dabs = w_diff[DIFF_W-1] ? -w_diff : w_diff;
    assign w_mag5 = {w_dabs[DMAG_W-1:0], 2'b00} + {2'b00, w_dabs[DMAG_W-1:0]};
    assign w_samp_num = w_mag5 + SNUM_W'(SAMPLE_RND);

    // trimmed sum times 11, rounded over 6N
    assign w_smag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_mag11 = {1'b0, w_smag, 3'b000} + {3'b000, w_smag, 1'b0}
                   + {4'b0000, w_smag};
    assign w_est_num = w_mag11 + ENUM_W'(EST_RND);

    pdtm_div #(
        .NUM_W (SNUM_W),
        .DEN   (SAMPLE_DEN)
    ) u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.accept),
        .i_num   (w_samp_num),
        .o_done  (w_sdiv_done),
        .o_quot  (w_squot)
    );

    pdtm_div #(
        .NUM_W (ENUM_W),
        .DEN   (EST_DEN)
    ) u_ediv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.est_start),
        .i_num   (w_est_num),
        .o_done  (w_ediv_done),
        .o_quot  (w_equot)
    );

    assign w_q_samp = w_squot[SAMPLE_W-1:0];
    assign w_qsat   = (w_equot > ENUM_W'(OUT_LIMIT)) ? (EST_W-1)'(OUT_LIMIT)
                                                     : w_equot[EST_W-2:0];
    assign w_est    = r_neg ? -$signed({1'b0, w_qsat}) : $signed({1'b0, w_qsat});

    // read address: two slots below the insertion point, sum sweep, or top of fill
    always_comb begin
        priority if (i_cmd.rd_sum) begin
            w_raddr = r_k;
        end else if (i_cmd.rd_shift) begin
            w_raddr = (r_j >= AW'(2)) ? r_j - AW'(2) : '0;
        end else begin
            w_raddr = (r_fill != '0) ? r_fill - AW'(1) : '0;
        end
    end

    assign w_we    = i_cmd.ins_step | i_cmd.ins_place;
    assign w_wdata = i_cmd.ins_step ? w_rdata : r_key;

    pdtm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BATCH_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_j),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib     <= '0;
            r_fill      <= '0;
            r_acc_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_calib <= i_cfg_wdata;
            end
            if (i_cmd.ins_place) begin
                r_fill <= (r_fill == AW'(BATCH_LEN - 1)) ? '0 : r_fill + AW'(1);
            end
            if (i_cmd.sum_init) begin
                r_acc_v <= 1'b0;
            end else if (i_cmd.sum_run) begin
                r_acc_v <= (r_k != AW'(KEND));
            end
            r_out_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_neg <= w_diff[DIFF_W-1];
        end else if (i_cmd.est_start) begin
            r_neg <= r_sum[SUM_W-1];
        end
        if (i_cmd.key_load) begin
            r_key <= r_neg ? -$signed(w_q_samp) : $signed(w_q_samp);
            r_j   <= r_fill;
        end else if (i_cmd.ins_step) begin
            r_j <= r_j - AW'(1);
        end
        if (i_cmd.sum_init) begin
            r_k   <= AW'(TRIM);
            r_sum <= '0;
        end else if (i_cmd.sum_run) begin
            if (r_k != AW'(KEND)) begin
                r_k <= r_k + AW'(1);
            end
            if (r_acc_v) begin
                r_sum <= r_sum + SUM_W'($signed(w_rdata));
            end
        end
        if (i_cmd.emit) begin
            r_est <= w_est;
        end
    end

    assign o_status.in_range    = (w_diff > LIM_LO) && (w_diff < LIM_HI);
    assign o_status.div_done    = w_sdiv_done | w_ediv_done;
    assign o_status.j_zero      = (r_j == '0);
    assign o_status.gt          = $signed(w_rdata) > r_key;
    assign o_status.last_sample = (r_fill == AW'(BATCH_LEN - 1));
    assign o_status.sum_done    = (r_k == AW'(KEND)) && !r_acc_v;

    assign o_valid          = r_out_valid;
    assign o_delay_estimate = r_est;

    `PDTM_ASSERT(a_strobe_single, i_clk, i_rst_n, r_out_valid |=> !r_out_valid,
        "result strobe held longer than one cycle")
    `PDTM_ASSERT(a_est_limits, i_clk, i_rst_n,
        r_out_valid |-> (r_est <= EST_MAX && r_est >= -EST_MAX),
        "estimate outside saturation limits")
    `PDTM_ASSERT(a_batch_restart, i_clk, i_rst_n, r_out_valid |-> (r_fill == '0),
        "result emitted without restarting the batch")

endmodule

>>> src/pdtm_ctrl.sv
// Controller state machine sequencing divide, insertion, sum and emit
module pdtm_ctrl import pdtm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SDIV = 5'b00010,
        ST_INS  = 5'b00100,
        ST_SUM  = 5'b01000,
        ST_EDIV = 5'b10000
    } t_state;

    t_state  r_state, n_state;
    t_dp_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                // out-of-range pairs are taken and dropped here
                if (i_start && i_status.in_range) begin
                    w_cmd.accept = 1'b1;
                    n_state      = ST_SDIV;
                end
            end
            ST_SDIV: begin
                if (i_status.div_done) begin
                    w_cmd.key_load = 1'b1;
                    n_state        = ST_INS;
                end
            end
            ST_INS: begin
                w_cmd.rd_shift = 1'b1;
                if (!i_status.j_zero && i_status.gt) begin
                    w_cmd.ins_step = 1'b1;
                end else begin
                    w_cmd.ins_place = 1'b1;
                    if (i_status.last_sample) begin
                        w_cmd.sum_init = 1'b1;
                        n_state        = ST_SUM;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SUM: begin
                w_cmd.rd_sum  = 1'b1;
                w_cmd.sum_run = 1'b1;
                if (i_status.sum_done) begin
                    w_cmd.est_start = 1'b1;
                    n_state         = ST_EDIV;
                end
            end
            ST_EDIV: begin
                if (i_status.div_done) begin
                    w_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = w_cmd;
    assign o_busy = (r_state != ST_IDLE);

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the phase delay trimmed mean estimator
`timescale 1ns / 1ps

module testbench;
    import pdtm_pkg::*;

    localparam int BATCH_LEN   = BATCH_LEN_DEF;
    localparam int TRIM        = BATCH_LEN / 4;
    localparam int DIV_CYCLES  = 2;
    // worst pair: scaling, full insertion walk, middle sweep, estimate scaling
    localparam int SETTLE      = 2 * (2 * DIV_CYCLES + 6 + 2 * BATCH_LEN);
    localparam int GOOD_PER_PHASE = 210;
    localparam int NUM_PHASES  = 7;

    typedef struct packed {
        logic signed [PHASE_W-1:0] a;
        logic signed [PHASE_W-1:0] b;
    } t_phase_pair;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic                      i_cfg_we;
    logic signed [CALIB_W-1:0] i_cfg_wdata;
    logic signed [PHASE_W-1:0] i_phase_a;
    logic signed [PHASE_W-1:0] i_phase_b;
    logic                      o_valid;
    logic signed [EST_W-1:0]   o_delay_estimate;

    t_phase_pair               pending_pairs[$];
    logic signed [EST_W-1:0]   expected_estimates[$];

    int calib_now;
    int sample_store[BATCH_LEN];
    int fill_count;
    int sent_count;
    int error_count;
    int good_count;
    t_phase_pair next_pair;

    phase_delay_trimmed_mean #(.BATCH_LEN(BATCH_LEN)) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_phase_a        (i_phase_a),
        .i_phase_b        (i_phase_b),
        .o_valid          (o_valid),
        .o_delay_estimate (o_delay_estimate)
    );

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR: %s", $time, msg);
        error_count++;
    endtask

    // nearest, ties away from zero; den > 0
    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint phase_diff(input logic signed [PHASE_W-1:0] a,
                                          input logic signed [PHASE_W-1:0] b,
                                          input int calib);
        return longint'(a) - longint'(b) - PHASE_BIAS - longint'(calib);
    endfunction

    function automatic bit in_window(input longint d);
        return d > -HALF_TURN && d < HALF_TURN;
    endfunction

    // predicts the effect of one accepted word on the batch
    task automatic take_pair(input logic signed [PHASE_W-1:0] a,
                             input logic signed [PHASE_W-1:0] b);
        longint d;
        longint sum;
        longint est;
        int sorted_batch[BATCH_LEN];
        int key;
        int j;
        d = phase_diff(a, b, calib_now);
        if (!in_window(d))
            return;
        if (fill_count >= BATCH_LEN)
            fill_count = 0;
        sample_store[fill_count] = int'(round_div(d * 5, 9));
        fill_count++;
        if (fill_count < BATCH_LEN)
            return;
        sorted_batch = sample_store;
        for (int i = 1; i < BATCH_LEN; i++) begin
            key = sorted_batch[i];
            j = i;
            while (j > 0 && sorted_batch[j-1] > key) begin
                sorted_batch[j] = sorted_batch[j-1];
                j--;
            end
            sorted_batch[j] = key;
        end
        sum = 0;
        for (int i = TRIM; i < BATCH_LEN - TRIM; i++)
            sum += sorted_batch[i];
        est = round_div(sum * 11, 6 * BATCH_LEN);
        if (est > OUT_LIMIT)
            est = OUT_LIMIT;
        if (est < -OUT_LIMIT)
            est = -OUT_LIMIT;
        expected_estimates.push_back(EST_W'(est));
        fill_count = 0;
    endtask

    task automatic push_pair(input int a, input int b);
        t_phase_pair p;
        p.a = PHASE_W'(a);
        p.b = PHASE_W'(b);
        if (in_window(phase_diff(p.a, p.b, calib_now)))
            good_count++;
        pending_pairs.push_back(p);
    endtask

    // random pair, mostly landing inside the window
    task automatic push_random_pair();
        int sel;
        int d;
        int k;
        int lo;
        int hi;
        int a;
        sel = $urandom_range(99);
        if (sel < 12) begin
            push_pair($urandom_range(16'hFFFF), $urandom_range(16'hFFFF));
            return;
        end
        for (int tries = 0; tries < 8; tries++) begin
            if (sel < 17) begin
                case ($urandom_range(3))
                    0: d = 17999;
                    1: d = -17999;
                    2: d = 18000;
                    default: d = -18000;
                endcase
            end else begin
                d = int'($urandom_range(35998)) - 17999;
            end
            k = d + PHASE_BIAS + calib_now;   // a - b must equal k
            if (k >= -65535 && k <= 65535) begin
                lo = (k - 32767 > -32768) ? k - 32767 : -32768;
                hi = (k + 32768 < 32767) ? k + 32768 : 32767;
                a = lo + int'($urandom_range(hi - lo));
                push_pair(a, a - k);
                return;
            end
        end
        push_pair($urandom_range(16'hFFFF), $urandom_range(16'hFFFF));
    endtask

    task automatic write_calib(input int value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CALIB_W'(value);
        calib_now = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic drain();
        while (pending_pairs.size() != 0 || start)
            @(posedge i_clk);
        while (expected_estimates.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // driver: start stays up until the word is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                take_pair(i_phase_a, i_phase_b);
            if (!start || !busy) begin
                if (pending_pairs.size() != 0 &&
                    !((sent_count < 700 || sent_count >= 1100) &&
                      $urandom_range(99) < 21)) begin
                    next_pair = pending_pairs.pop_front();
                    start     <= 1'b1;
                    i_phase_a <= next_pair.a;
                    i_phase_b <= next_pair.b;
                    sent_count++;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_estimates.size() == 0)
                report_mismatch($sformatf("unexpected estimate %0d", o_delay_estimate));
            else if (o_delay_estimate !== expected_estimates[0])
                report_mismatch($sformatf("delay_estimate %0d, expected %0d",
                                          o_delay_estimate, expected_estimates.pop_front()));
            else
                void'(expected_estimates.pop_front());
        end
    end

    initial begin
        #10ms;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        int calib_plan[NUM_PHASES];
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_phase_a   = '0;
        i_phase_b   = '0;
        calib_now   = 0;
        fill_count  = 0;
        sent_count  = 0;
        error_count = 0;
        good_count  = 0;
        calib_plan  = '{0, 36000, -36000, 65535, -65536,
                        int'($urandom_range(72000)) - 36000, 0};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_calib(calib_plan[ph]);
            good_count = 0;
            if (ph == 0) begin
                push_pair(18000, -18000);       // far outside
                push_pair(-18000, 18000);
                push_pair(23099, 0);            // d = +179.99 deg
                push_pair(-12899, 0);           // d = -179.99 deg
                push_pair(23100, 0);            // d = +180 deg exactly, dropped
                push_pair(-12900, 0);           // d = -180 deg exactly, dropped
                push_pair(16'h7FFF, 16'h8000);  // raw extremes, dropped
                push_pair(16'h8000, 16'h7FFF);
                push_pair(16'h8000, 16'h8000);  // equal extremes, in window
                push_pair(16'h7FFF, 16'h7FFF);
                push_pair(0, 0);
                push_pair(5100, 0);             // d = 0
                push_pair(18000, 18000);
                push_pair(-18000, -18000);
                push_pair(5101, 0);
                push_pair(5099, 0);
                push_pair(5109, 0);
                push_pair(5092, 0);
                push_pair(-18000, -18000 - 22000);
                push_pair(18000, 18000 + 4000);
            end
            while (good_count < GOOD_PER_PHASE)
                push_random_pair();
            drain();
        end

        if (expected_estimates.size() != 0)
            report_mismatch($sformatf("%0d estimates never arrived",
                                      expected_estimates.size()));
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
